// ===== src/dfs_pkg.sv =====
package dfs_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

	localparam int KEY_W = 32;
	localparam int POS_W = 16;
	localparam int SIZE_W = 15;
	localparam int CEN_W = 18;
	localparam int DIF_W = 19;
	localparam int MAG_W = 18;
	localparam int SQ_W = 36;
	localparam int SCORE_W = 39;

	typedef enum logic [2:0] {
		CMD_BEGIN = 3'd0,
		CMD_REGISTER = 3'd1,
		CMD_END = 3'd2,
		CMD_MOVE = 3'd3,
		CMD_SET = 3'd4,
		CMD_SELECT = 3'd5,
		CMD_CLEAR = 3'd6
	} cmd_t;

	typedef enum logic [1:0] {
		DIR_UP = 2'd0,
		DIR_DOWN = 2'd1,
		DIR_LEFT = 2'd2,
		DIR_RIGHT = 2'd3
	} dir_t;

	typedef enum logic [2:0] {
		SCAN_KEY_IN,
		SCAN_KEY_CUR,
		SCAN_NEAR_PREV,
		SCAN_NEAR_PT,
		SCAN_MOVE
	} scan_mode_t;

	typedef enum logic [1:0] {
		RD_FOUND,
		RD_BEST,
		RD_ZERO
	} rd_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_FIND,
		ST_EXEC,
		ST_SCAN,
		ST_RD_FOUND,
		ST_RD_BEST,
		ST_RD_ZERO,
		ST_APPLY,
		ST_RD_ORG,
		ST_APPLY_ORG,
		ST_FINAL,
		ST_FIND_CUR,
		ST_FINAL_RD,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [KEY_W-1:0] owner;
		logic [KEY_W-1:0] id;
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic [SIZE_W-1:0] w;
		logic [SIZE_W-1:0] h;
	} entry_t;

	typedef struct packed {
		logic [2:0] command;
		logic [KEY_W-1:0] owner;
		logic [KEY_W-1:0] id;
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic [SIZE_W-1:0] w;
		logic [SIZE_W-1:0] h;
		logic enabled;
		logic [1:0] dir;
		logic pv;
	} item_t;

	typedef struct packed {
		logic in_ready;
		logic clr_flags;
		logic scan_start;
		scan_mode_t scan_mode;
		logic rd_req;
		rd_sel_t rd_sel;
		logic wr_en;
		logic wr_at_count;
		logic count_inc;
		logic count_clr;
		logic collect_set;
		logic collect_clr;
		logic prev_load;
		logic prev_clr;
		logic focus_rd;
		logic focus_in;
		logic focus_drop;
		logic origin_load;
		logic set_ok;
		logic set_full;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic in_valid;
		logic [2:0] command;
		logic found;
		logic has_focus;
		logic collecting;
		logic count_zero;
		logic count_full;
		logic has_prev;
		logic pv;
		logic reg_ok;
		logic owner_zero;
		logic scan_done;
		logic best_valid;
		logic out_busy;
	} dp_status_t;

	function automatic logic signed [CEN_W-1:0] center2(logic signed [POS_W-1:0] p,
			logic [SIZE_W-1:0] s);
		return $signed({p[POS_W-1], p, 1'b0}) + $signed({3'b000, s});
	endfunction

endpackage

// ===== src/dfs_if.sv =====
interface dfs_req_if;
	logic valid;
	logic ready;
	logic [2:0] command;
	logic [dfs_pkg::KEY_W-1:0] owner_key;
	logic [dfs_pkg::KEY_W-1:0] entry_id;
	logic signed [dfs_pkg::POS_W-1:0] pos_x;
	logic signed [dfs_pkg::POS_W-1:0] pos_y;
	logic [dfs_pkg::SIZE_W-1:0] rect_width;
	logic [dfs_pkg::SIZE_W-1:0] rect_height;
	logic entry_enabled;
	logic [1:0] move_direction;
	logic point_valid;

	modport source (output valid, command, owner_key, entry_id, pos_x, pos_y, rect_width,
		rect_height, entry_enabled, move_direction, point_valid, input ready);
	modport sink (input valid, command, owner_key, entry_id, pos_x, pos_y, rect_width,
		rect_height, entry_enabled, move_direction, point_valid, output ready);
endinterface

interface dfs_rsp_if;
	logic valid;
	logic ready;
	logic accepted;
	logic focus_valid;
	logic [dfs_pkg::KEY_W-1:0] focus_owner;
	logic [dfs_pkg::KEY_W-1:0] focus_id;
	logic signed [dfs_pkg::POS_W-1:0] focus_x;
	logic signed [dfs_pkg::POS_W-1:0] focus_y;
	logic [dfs_pkg::SIZE_W-1:0] focus_width;
	logic [dfs_pkg::SIZE_W-1:0] focus_height;
	logic table_full;

	modport source (output valid, accepted, focus_valid, focus_owner, focus_id, focus_x,
		focus_y, focus_width, focus_height, table_full, input ready);
	modport sink (input valid, accepted, focus_valid, focus_owner, focus_id, focus_x,
		focus_y, focus_width, focus_height, table_full, output ready);
endinterface

// ===== src/directional_focus_selector_core.sv =====
// Channel   Modport  Moves
// request   sink     one command item: command, key, rectangle or point, direction
// response  source   one result item per command: accepted, focus entry, table_full
//
// Each item runs two key searches over the table entries, and end_frame, move and
// select_nearest add at most one distance scan.
// All scans share the single read port of the entry memory, one entry per cycle.
// One item is worked at a time; request.ready is high only while the block is idle.
// The result register lets the next item be taken while a result waits for response.ready;
// a result that is still waiting holds the block in its last state until it is taken.
// Reset clears all control state; the entry memory is not cleared.
module directional_focus_selector_core (
	input logic clk,
	input logic arst_n,
	dfs_req_if.sink request,
	dfs_rsp_if.source response
);
	import dfs_pkg::*;

	ctrl_cmd_t cmd;
	dp_status_t st;

	dfs_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.st(st),
		.cmd(cmd)
	);

	dfs_datapath u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.request(request),
		.response(response),
		.cmd(cmd),
		.st(st)
	);

endmodule

// ===== src/dfs_ctrl.sv =====
module dfs_ctrl (
	input logic clk,
	input logic arst_n,
	input dfs_pkg::dp_status_t st,
	output dfs_pkg::ctrl_cmd_t cmd
);
	import dfs_pkg::*;

	state_t state_q, state_d;
	logic found_cur;

	assign found_cur = st.found && st.has_focus;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (st.in_valid) state_d = ST_START;
			end
			ST_START: state_d = ST_FIND;
			ST_FIND: begin
				if (st.scan_done) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = ST_FINAL;
				case (st.command)
					CMD_BEGIN: begin
						if (found_cur) state_d = ST_RD_FOUND;
					end
					CMD_END: begin
						if (!st.count_zero && !found_cur) begin
							if (st.has_prev || st.pv) state_d = ST_SCAN;
							else state_d = ST_RD_ZERO;
						end
					end
					CMD_MOVE: begin
						if (!st.collecting && !st.count_zero) begin
							state_d = found_cur ? ST_RD_ORG : ST_RD_ZERO;
						end
					end
					CMD_SELECT: begin
						if (!st.collecting && !st.count_zero && st.pv) state_d = ST_SCAN;
					end
					default: state_d = ST_FINAL;
				endcase
			end
			ST_SCAN: begin
				if (st.scan_done) begin
					if (st.command == CMD_MOVE && !st.best_valid) state_d = ST_FINAL;
					else state_d = ST_RD_BEST;
				end
			end
			ST_RD_FOUND, ST_RD_BEST, ST_RD_ZERO: state_d = ST_APPLY;
			ST_APPLY: state_d = ST_FINAL;
			ST_RD_ORG: state_d = ST_APPLY_ORG;
			ST_APPLY_ORG: state_d = ST_SCAN;
			ST_FINAL: state_d = ST_FIND_CUR;
			ST_FIND_CUR: begin
				if (st.scan_done) state_d = found_cur ? ST_FINAL_RD : ST_OUT;
			end
			ST_FINAL_RD: state_d = ST_OUT;
			ST_OUT: begin
				if (!st.out_busy) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.scan_mode = SCAN_KEY_CUR;
		cmd.rd_sel = RD_FOUND;
		case (state_q)
			ST_IDLE: cmd.in_ready = 1'b1;
			ST_START: begin
				cmd.clr_flags = 1'b1;
				cmd.scan_start = 1'b1;
				if (st.command == CMD_REGISTER || st.command == CMD_SET) begin
					cmd.scan_mode = SCAN_KEY_IN;
				end
			end
			ST_EXEC: begin
				case (st.command)
					CMD_BEGIN: begin
						if (!found_cur) begin
							cmd.count_clr = 1'b1;
							cmd.collect_set = 1'b1;
							cmd.prev_clr = 1'b1;
							cmd.set_ok = 1'b1;
						end
					end
					CMD_REGISTER: begin
						if (st.collecting && st.reg_ok) begin
							if (st.found) begin
								cmd.wr_en = 1'b1;
								cmd.set_ok = 1'b1;
							end else if (st.count_full) begin
								cmd.set_full = 1'b1;
							end else begin
								cmd.wr_en = 1'b1;
								cmd.wr_at_count = 1'b1;
								cmd.count_inc = 1'b1;
								cmd.set_ok = 1'b1;
							end
						end
					end
					CMD_END: begin
						if (st.count_zero || found_cur) begin
							cmd.collect_clr = 1'b1;
							cmd.prev_clr = 1'b1;
							cmd.focus_drop = st.count_zero;
							cmd.set_ok = 1'b1;
						end else if (st.has_prev) begin
							cmd.scan_start = 1'b1;
							cmd.scan_mode = SCAN_NEAR_PREV;
						end else if (st.pv) begin
							cmd.scan_start = 1'b1;
							cmd.scan_mode = SCAN_NEAR_PT;
						end
					end
					CMD_SET: begin
						if (!st.collecting && !st.owner_zero && st.found) begin
							cmd.focus_in = 1'b1;
							cmd.set_ok = 1'b1;
						end
					end
					CMD_SELECT: begin
						if (!st.collecting && !st.count_zero && st.pv) begin
							cmd.scan_start = 1'b1;
							cmd.scan_mode = SCAN_NEAR_PT;
						end
					end
					CMD_CLEAR: begin
						cmd.count_clr = 1'b1;
						cmd.focus_drop = 1'b1;
						cmd.prev_clr = 1'b1;
						cmd.collect_clr = 1'b1;
						cmd.set_ok = 1'b1;
					end
					default: cmd.set_ok = 1'b0;
				endcase
			end
			ST_RD_FOUND, ST_RD_ORG, ST_FINAL_RD: begin
				cmd.rd_req = 1'b1;
				cmd.rd_sel = RD_FOUND;
			end
			ST_RD_BEST: begin
				cmd.rd_req = 1'b1;
				cmd.rd_sel = RD_BEST;
			end
			ST_RD_ZERO: begin
				cmd.rd_req = 1'b1;
				cmd.rd_sel = RD_ZERO;
			end
			ST_APPLY: begin
				cmd.set_ok = 1'b1;
				if (st.command == CMD_BEGIN) begin
					cmd.prev_load = 1'b1;
					cmd.count_clr = 1'b1;
					cmd.collect_set = 1'b1;
				end else begin
					cmd.focus_rd = 1'b1;
					if (st.command == CMD_END) begin
						cmd.collect_clr = 1'b1;
						cmd.prev_clr = 1'b1;
					end
				end
			end
			ST_APPLY_ORG: begin
				cmd.origin_load = 1'b1;
				cmd.scan_start = 1'b1;
				cmd.scan_mode = SCAN_MOVE;
			end
			ST_FINAL: begin
				cmd.scan_start = 1'b1;
				cmd.scan_mode = SCAN_KEY_CUR;
			end
			ST_OUT: cmd.out_load = !st.out_busy;
			default: cmd.in_ready = 1'b0;
		endcase
	end

endmodule

// ===== src/dfs_datapath.sv =====
module dfs_datapath (
	input logic clk,
	input logic arst_n,
	dfs_req_if.sink request,
	dfs_rsp_if.source response,
	input dfs_pkg::ctrl_cmd_t cmd,
	output dfs_pkg::dp_status_t st
);
	import dfs_pkg::*;

	entry_t mem [MAX_ENTRIES];
	entry_t rd_data_q;
	item_t in_q;

	logic [CNT_W-1:0] count_q;
	logic [KEY_W-1:0] cur_owner_q, cur_id_q;
	logic has_focus_q, has_prev_q, collecting_q, ok_q, full_q;
	logic signed [CEN_W-1:0] prev_x2_q, prev_y2_q, org_x2_q, org_y2_q;

	logic scan_act_q;
	logic [CNT_W-1:0] scan_i_q;
	scan_mode_t mode_q;
	logic v_s1, v_s2, elig_s2;
	logic [IDX_W-1:0] idx_s1, idx_s2;
	logic [SQ_W-1:0] pp_s2, qq_s2;
	logic [MAG_W-1:0] prim_s2;

	logic found_q, best_valid_q;
	logic [IDX_W-1:0] found_idx_q, best_idx_q;
	logic [SCORE_W-1:0] best_score_q;
	logic [MAG_W-1:0] best_prim_q;

	logic out_valid_q;
	logic issue, rd_en, scan_done;
	logic [IDX_W-1:0] rd_addr, wr_addr;
	logic signed [CEN_W-1:0] rcx, rcy, ref_x, ref_y;
	logic signed [DIF_W-1:0] dx, dy;
	logic [DIF_W-1:0] ndx, ndy;
	logic [MAG_W-1:0] ax, ay, p, q;
	logic elig;
	logic [KEY_W-1:0] key_owner, key_id;
	logic key_hit;
	logic [SCORE_W-1:0] score;
	logic take;

	assign request.ready = cmd.in_ready;

	// Scan: one read issued per cycle, key match on the read data, squares one stage later.
	assign issue = scan_act_q && (scan_i_q < count_q);
	assign scan_done = scan_act_q && !issue && !v_s1 && !v_s2;
	assign rd_en = issue || cmd.rd_req;

	always_comb begin
		rd_addr = scan_i_q[IDX_W-1:0];
		if (!issue) begin
			case (cmd.rd_sel)
				RD_FOUND: rd_addr = found_idx_q;
				RD_BEST: rd_addr = best_idx_q;
				default: rd_addr = '0;
			endcase
		end
	end

	assign wr_addr = cmd.wr_at_count ? count_q[IDX_W-1:0] : found_idx_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= '{owner: in_q.owner, id: in_q.id, x: in_q.x, y: in_q.y,
				w: in_q.w, h: in_q.h};
		end
		if (rd_en) rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (request.valid && cmd.in_ready) begin
			in_q <= '{command: request.command, owner: request.owner_key,
				id: request.entry_id, x: request.pos_x, y: request.pos_y,
				w: request.rect_width, h: request.rect_height,
				enabled: request.entry_enabled, dir: request.move_direction,
				pv: request.point_valid};
		end
	end

	assign key_owner = (mode_q == SCAN_KEY_IN) ? in_q.owner : cur_owner_q;
	assign key_id = (mode_q == SCAN_KEY_IN) ? in_q.id : cur_id_q;
	assign key_hit = (rd_data_q.owner == key_owner) && (rd_data_q.id == key_id);

	assign rcx = center2(rd_data_q.x, rd_data_q.w);
	assign rcy = center2(rd_data_q.y, rd_data_q.h);

	always_comb begin
		case (mode_q)
			SCAN_NEAR_PREV: begin
				ref_x = prev_x2_q;
				ref_y = prev_y2_q;
			end
			SCAN_NEAR_PT: begin
				ref_x = $signed({in_q.x[POS_W-1], in_q.x, 1'b0});
				ref_y = $signed({in_q.y[POS_W-1], in_q.y, 1'b0});
			end
			default: begin
				ref_x = org_x2_q;
				ref_y = org_y2_q;
			end
		endcase
	end

	assign dx = $signed({rcx[CEN_W-1], rcx}) - $signed({ref_x[CEN_W-1], ref_x});
	assign dy = $signed({rcy[CEN_W-1], rcy}) - $signed({ref_y[CEN_W-1], ref_y});
	assign ndx = -dx;
	assign ndy = -dy;
	assign ax = dx[DIF_W-1] ? ndx[MAG_W-1:0] : dx[MAG_W-1:0];
	assign ay = dy[DIF_W-1] ? ndy[MAG_W-1:0] : dy[MAG_W-1:0];

	always_comb begin
		p = ax;
		q = ay;
		elig = 1'b1;
		if (mode_q == SCAN_MOVE) begin
			case (in_q.dir)
				DIR_UP: begin
					p = ay;
					q = ax;
					elig = dy[DIF_W-1];
				end
				DIR_DOWN: begin
					p = ay;
					q = ax;
					elig = !dy[DIF_W-1] && (dy != '0);
				end
				DIR_LEFT: elig = dx[DIF_W-1];
				default: elig = !dx[DIF_W-1] && (dx != '0);
			endcase
			if (idx_s1 == found_idx_q) elig = 1'b0;
		end
	end

	// The perpendicular square carries a weight of four only when stepping.
	assign score = (mode_q == SCAN_MOVE) ? ({3'b000, pp_s2} + {1'b0, qq_s2, 2'b00})
		: ({3'b000, pp_s2} + {3'b000, qq_s2});
	assign take = v_s2 && elig_s2 && (!best_valid_q || (score < best_score_q) ||
		((mode_q == SCAN_MOVE) && (score == best_score_q) && (prim_s2 < best_prim_q)));

	always_ff @(posedge clk) begin
		idx_s1 <= rd_addr;
		idx_s2 <= idx_s1;
		elig_s2 <= elig;
		pp_s2 <= p * p;
		qq_s2 <= q * q;
		prim_s2 <= p;
		if (take) begin
			best_idx_q <= idx_s2;
			best_score_q <= score;
			best_prim_q <= prim_s2;
		end
		if (v_s1 && !found_q && key_hit &&
				(mode_q == SCAN_KEY_IN || mode_q == SCAN_KEY_CUR)) begin
			found_idx_q <= idx_s1;
		end
		if (cmd.prev_load) begin
			prev_x2_q <= rcx;
			prev_y2_q <= rcy;
		end
		if (cmd.origin_load) begin
			org_x2_q <= rcx;
			org_y2_q <= rcy;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_act_q <= 1'b0;
			scan_i_q <= '0;
			mode_q <= SCAN_KEY_CUR;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			found_q <= 1'b0;
			best_valid_q <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1 && (mode_q == SCAN_NEAR_PREV || mode_q == SCAN_NEAR_PT ||
				mode_q == SCAN_MOVE);
			if (take) best_valid_q <= 1'b1;
			if (v_s1 && key_hit && (mode_q == SCAN_KEY_IN || mode_q == SCAN_KEY_CUR)) begin
				found_q <= 1'b1;
			end
			if (issue) scan_i_q <= scan_i_q + 1'b1;
			if (scan_done) scan_act_q <= 1'b0;
			if (cmd.scan_start) begin
				scan_act_q <= 1'b1;
				scan_i_q <= '0;
				mode_q <= cmd.scan_mode;
				found_q <= 1'b0;
				best_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cur_owner_q <= '0;
			cur_id_q <= '0;
			has_focus_q <= 1'b0;
			has_prev_q <= 1'b0;
			collecting_q <= 1'b0;
			ok_q <= 1'b0;
			full_q <= 1'b0;
		end else begin
			if (cmd.clr_flags) begin
				ok_q <= 1'b0;
				full_q <= 1'b0;
			end
			if (cmd.set_ok) ok_q <= 1'b1;
			if (cmd.set_full) full_q <= 1'b1;
			if (cmd.count_inc) count_q <= count_q + 1'b1;
			if (cmd.count_clr) count_q <= '0;
			if (cmd.collect_set) collecting_q <= 1'b1;
			if (cmd.collect_clr) collecting_q <= 1'b0;
			if (cmd.prev_load) has_prev_q <= 1'b1;
			if (cmd.prev_clr) has_prev_q <= 1'b0;
			if (cmd.focus_rd) begin
				cur_owner_q <= rd_data_q.owner;
				cur_id_q <= rd_data_q.id;
				has_focus_q <= 1'b1;
			end
			if (cmd.focus_in) begin
				cur_owner_q <= in_q.owner;
				cur_id_q <= in_q.id;
				has_focus_q <= 1'b1;
			end
			if (cmd.focus_drop) begin
				cur_owner_q <= '0;
				cur_id_q <= '0;
				has_focus_q <= 1'b0;
			end
		end
	end

	// Result register: a new item may start while the last result waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (response.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			response.accepted <= ok_q;
			response.table_full <= full_q;
			if (found_q && has_focus_q) begin
				response.focus_valid <= 1'b1;
				response.focus_owner <= rd_data_q.owner;
				response.focus_id <= rd_data_q.id;
				response.focus_x <= rd_data_q.x;
				response.focus_y <= rd_data_q.y;
				response.focus_width <= rd_data_q.w;
				response.focus_height <= rd_data_q.h;
			end else begin
				response.focus_valid <= 1'b0;
				response.focus_owner <= '0;
				response.focus_id <= '0;
				response.focus_x <= '0;
				response.focus_y <= '0;
				response.focus_width <= '0;
				response.focus_height <= '0;
			end
		end
	end

	assign response.valid = out_valid_q;

	assign st.in_valid = request.valid;
	assign st.command = in_q.command;
	assign st.found = found_q;
	assign st.has_focus = has_focus_q;
	assign st.collecting = collecting_q;
	assign st.count_zero = (count_q == '0);
	assign st.count_full = (count_q >= CNT_W'(MAX_ENTRIES));
	assign st.has_prev = has_prev_q;
	assign st.pv = in_q.pv;
	assign st.reg_ok = (in_q.owner != '0) && in_q.enabled && (in_q.w != '0) &&
		(in_q.h != '0);
	assign st.owner_zero = (in_q.owner == '0);
	assign st.scan_done = scan_done;
	assign st.best_valid = best_valid_q;
	assign st.out_busy = out_valid_q && !response.ready;

endmodule

// ===== tb/tb_directional_focus_selector_core.sv =====
module tb_directional_focus_selector_core;
	timeunit 1ns;
	timeprecision 1ps;
	import dfs_pkg::*;

	localparam int RANDOM_ITEMS = 1300;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int DRAIN_CYCLES = 300;

	typedef struct packed {
		logic accepted;
		logic focus_valid;
		logic [KEY_W-1:0] owner;
		logic [KEY_W-1:0] id;
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic [SIZE_W-1:0] w;
		logic [SIZE_W-1:0] h;
		logic table_full;
	} focus_res_t;

	typedef struct {
		item_t cmd_item;
		bit fixed;
		focus_res_t fixed_res;
	} stim_row_t;

	logic clk;
	logic arst_n;

	dfs_req_if request();
	dfs_rsp_if response();

	directional_focus_selector_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.request(request),
		.response(response)
	);

	// Shadow copy of the focus table and control state.
	entry_t shadow_tbl[MAX_ENTRIES];
	int shadow_cx2[MAX_ENTRIES];
	int shadow_cy2[MAX_ENTRIES];
	int shadow_count;
	logic [KEY_W-1:0] shadow_owner;
	logic [KEY_W-1:0] shadow_id;
	bit shadow_focus;
	int saved_cx2;
	int saved_cy2;
	bit saved_valid;
	bit shadow_collecting;

	stim_row_t stim_rows[$];
	focus_res_t pending_focus[$];
	int loaded;
	int taken;
	int mismatches;
	int cycles;
	bit drive_fixed;
	focus_res_t drive_res;

	function automatic int key_index(logic [KEY_W-1:0] owner, logic [KEY_W-1:0] id);
		for (int i = 0; i < shadow_count; i++) begin
			if (shadow_tbl[i].owner == owner && shadow_tbl[i].id == id) begin
				return i;
			end
		end
		return -1;
	endfunction

	function automatic int focus_index();
		return shadow_focus ? key_index(shadow_owner, shadow_id) : -1;
	endfunction

	function automatic int nearest_index(int px2, int py2);
		int best;
		longint best_d;
		longint dx;
		longint dy;
		longint d;
		best = 0;
		best_d = 0;
		for (int i = 0; i < shadow_count; i++) begin
			dx = longint'(shadow_cx2[i]) - px2;
			dy = longint'(shadow_cy2[i]) - py2;
			d = dx * dx + dy * dy;
			if (i == 0 || d < best_d) begin
				best = i;
				best_d = d;
			end
		end
		return best;
	endfunction

	function automatic void take_focus(int i);
		shadow_owner = shadow_tbl[i].owner;
		shadow_id = shadow_tbl[i].id;
		shadow_focus = 1'b1;
	endfunction

	function automatic void drop_focus();
		shadow_focus = 1'b0;
		shadow_owner = '0;
		shadow_id = '0;
	endfunction

	function automatic bit step_focus(dir_t dir);
		int cur;
		int best;
		longint dx;
		longint dy;
		longint prim;
		longint perp;
		longint score;
		longint best_score;
		longint best_prim;
		best = -1;
		best_score = 0;
		best_prim = 0;
		if (shadow_collecting || shadow_count == 0) begin
			return 1'b0;
		end
		cur = focus_index();
		if (cur < 0) begin
			take_focus(0);
			return 1'b1;
		end
		for (int i = 0; i < shadow_count; i++) begin
			if (i == cur) begin
				continue;
			end
			dx = longint'(shadow_cx2[i]) - shadow_cx2[cur];
			dy = longint'(shadow_cy2[i]) - shadow_cy2[cur];
			case (dir)
				DIR_UP: begin
					if (dy >= 0) continue;
					prim = -dy;
					perp = dx < 0 ? -dx : dx;
				end
				DIR_DOWN: begin
					if (dy <= 0) continue;
					prim = dy;
					perp = dx < 0 ? -dx : dx;
				end
				DIR_LEFT: begin
					if (dx >= 0) continue;
					prim = -dx;
					perp = dy < 0 ? -dy : dy;
				end
				default: begin
					if (dx <= 0) continue;
					prim = dx;
					perp = dy < 0 ? -dy : dy;
				end
			endcase
			score = prim * prim + 4 * perp * perp;
			if (best < 0 || score < best_score || (score == best_score && prim < best_prim)) begin
				best = i;
				best_score = score;
				best_prim = prim;
			end
		end
		if (best < 0) begin
			return 1'b0;
		end
		take_focus(best);
		return 1'b1;
	endfunction

	function automatic focus_res_t focus_after(item_t it);
		focus_res_t r;
		int i;
		bit ok;
		bit full;
		ok = 1'b0;
		full = 1'b0;
		case (it.command)
			CMD_BEGIN: begin
				saved_valid = 1'b0;
				i = focus_index();
				if (i >= 0) begin
					saved_cx2 = shadow_cx2[i];
					saved_cy2 = shadow_cy2[i];
					saved_valid = 1'b1;
				end
				shadow_count = 0;
				shadow_collecting = 1'b1;
				ok = 1'b1;
			end
			CMD_REGISTER: begin
				if (shadow_collecting && it.owner != 0 && it.enabled && it.w != 0 && it.h != 0) begin
					i = key_index(it.owner, it.id);
					if (i < 0) begin
						if (shadow_count >= MAX_ENTRIES) begin
							full = 1'b1;
						end else begin
							i = shadow_count;
							shadow_count++;
						end
					end
					if (i >= 0) begin
						shadow_tbl[i] = '{owner: it.owner, id: it.id, x: it.x, y: it.y,
							w: it.w, h: it.h};
						shadow_cx2[i] = 2 * int'(it.x) + int'(it.w);
						shadow_cy2[i] = 2 * int'(it.y) + int'(it.h);
						ok = 1'b1;
					end
				end
			end
			CMD_END: begin
				shadow_collecting = 1'b0;
				ok = 1'b1;
				if (shadow_count == 0) begin
					drop_focus();
				end else if (focus_index() < 0) begin
					i = 0;
					if (saved_valid) begin
						i = nearest_index(saved_cx2, saved_cy2);
					end else if (it.pv) begin
						i = nearest_index(2 * int'(it.x), 2 * int'(it.y));
					end
					take_focus(i);
				end
				saved_valid = 1'b0;
			end
			CMD_MOVE: ok = step_focus(dir_t'(it.dir));
			CMD_SET: begin
				if (!shadow_collecting && it.owner != 0 && key_index(it.owner, it.id) >= 0) begin
					shadow_owner = it.owner;
					shadow_id = it.id;
					shadow_focus = 1'b1;
					ok = 1'b1;
				end
			end
			CMD_SELECT: begin
				if (!shadow_collecting && shadow_count != 0 && it.pv) begin
					take_focus(nearest_index(2 * int'(it.x), 2 * int'(it.y)));
					ok = 1'b1;
				end
			end
			CMD_CLEAR: begin
				shadow_count = 0;
				drop_focus();
				saved_valid = 1'b0;
				shadow_collecting = 1'b0;
				ok = 1'b1;
			end
			default: ;
		endcase
		r = '0;
		r.accepted = ok;
		r.table_full = full;
		i = focus_index();
		if (i >= 0) begin
			r.focus_valid = 1'b1;
			r.owner = shadow_tbl[i].owner;
			r.id = shadow_tbl[i].id;
			r.x = shadow_tbl[i].x;
			r.y = shadow_tbl[i].y;
			r.w = shadow_tbl[i].w;
			r.h = shadow_tbl[i].h;
		end
		return r;
	endfunction

	function automatic item_t noise_item();
		item_t it;
		it.command = 3'($urandom_range(0, 7));
		it.owner = $urandom();
		it.id = $urandom();
		it.x = 16'($urandom());
		it.y = 16'($urandom());
		it.w = 15'($urandom());
		it.h = 15'($urandom());
		it.enabled = 1'($urandom());
		it.dir = 2'($urandom());
		it.pv = 1'($urandom());
		return it;
	endfunction

	function automatic item_t make_item(cmd_t c, logic [KEY_W-1:0] owner, logic [KEY_W-1:0] id,
			int x, int y, int w, int h, bit en, dir_t dir, bit pv);
		item_t it;
		it = '{command: c, owner: owner, id: id, x: 16'(x), y: 16'(y), w: 15'(w), h: 15'(h),
			enabled: en, dir: dir, pv: pv};
		return it;
	endfunction

	function automatic void add_row(item_t it, bit fixed = 1'b0, bit acc = 1'b0);
		stim_row_t row;
		row.cmd_item = it;
		row.fixed = fixed;
		row.fixed_res = '0;
		row.fixed_res.accepted = acc;
		stim_rows.insert(stim_rows.size(), row);
	endfunction

	// Register item, enabled in most cases, with a key drawn mostly from a small pool (or unique
	// per k when unique_key is set), so that duplicates and later set_current hits are common.
	function automatic item_t random_register(bit unique_key, int k);
		item_t it;
		it = noise_item();
		it.command = CMD_REGISTER;
		if (unique_key) begin
			it.owner = 32'(k + 1);
		end else if ($urandom_range(0, 3) != 0) begin
			it.owner = $urandom_range(1, 3);
			it.id = $urandom_range(0, 3);
		end
		if (it.owner == 0) it.owner = 1;
		if ($urandom_range(0, 1) != 0) begin
			it.w = 15'($urandom_range(1, 64));
			it.h = 15'($urandom_range(1, 64));
			it.x = 16'($signed($urandom_range(0, 400)) - 200);
			it.y = 16'($signed($urandom_range(0, 400)) - 200);
		end
		if (it.w == 0) it.w = 1;
		if (it.h == 0) it.h = 1;
		it.enabled = $urandom_range(0, 15) != 0;
		return it;
	endfunction

	function automatic void build_stimulus();
		item_t it;
		int n;
		bit big;
		// Directed part: empty block, malformed registers, extremes, every command.
		add_row(make_item(CMD_MOVE, 0, 0, 0, 0, 0, 0, 0, DIR_UP, 0), 1, 0);
		add_row(make_item(cmd_t'(3'b111), '1, '1, -1, -1, 32767, 32767, 1, DIR_RIGHT, 1), 1, 0);
		add_row(make_item(CMD_REGISTER, 5, 5, 0, 0, 10, 10, 1, DIR_UP, 0), 1, 0);
		add_row(make_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, DIR_UP, 0), 1, 1);
		add_row(make_item(CMD_BEGIN, 0, 0, 0, 0, 0, 0, 0, DIR_UP, 0), 1, 1);
		add_row(make_item(CMD_END, 0, 0, 100, 100, 0, 0, 0, DIR_UP, 1), 1, 1);
		add_row(make_item(CMD_BEGIN, 0, 0, 0, 0, 0, 0, 0, DIR_UP, 0), 1, 1);
		add_row(make_item(CMD_REGISTER, 0, 7, 0, 0, 10, 10, 1, DIR_UP, 0), 1, 0);
		add_row(make_item(CMD_REGISTER, 2, 7, 0, 0, 0, 10, 1, DIR_UP, 0), 1, 0);
		add_row(make_item(CMD_REGISTER, 2, 7, 0, 0, 10, 0, 1, DIR_UP, 0), 1, 0);
		add_row(make_item(CMD_REGISTER, 2, 7, 0, 0, 10, 10, 0, DIR_UP, 0), 1, 0);
		add_row(make_item(CMD_REGISTER, '1, 0, -32768, 32767, 32767, 32767, 1, DIR_UP, 0), 1, 1);
		add_row(make_item(CMD_REGISTER, 1, '1, 32767, -32768, 1, 1, 1, DIR_UP, 0));
		add_row(make_item(CMD_REGISTER, 1, '1, 32000, -32768, 2, 3, 1, DIR_UP, 0));
		add_row(make_item(CMD_REGISTER, 3, 3, 0, 0, 16, 16, 1, DIR_UP, 0));
		add_row(make_item(CMD_MOVE, 0, 0, 0, 0, 0, 0, 0, DIR_DOWN, 0), 1, 0);
		add_row(make_item(CMD_SET, 3, 3, 0, 0, 0, 0, 0, DIR_UP, 0));
		add_row(make_item(CMD_END, 0, 0, 32767, -32768, 0, 0, 0, DIR_UP, 1));
		add_row(make_item(CMD_MOVE, 0, 0, 0, 0, 0, 0, 0, DIR_UP, 0));
		add_row(make_item(CMD_MOVE, 0, 0, 0, 0, 0, 0, 0, DIR_DOWN, 0));
		add_row(make_item(CMD_MOVE, 0, 0, 0, 0, 0, 0, 0, DIR_LEFT, 0));
		add_row(make_item(CMD_MOVE, 0, 0, 0, 0, 0, 0, 0, DIR_RIGHT, 0));
		add_row(make_item(CMD_SET, 9, 9, 0, 0, 0, 0, 0, DIR_UP, 0));
		add_row(make_item(CMD_SET, 3, 3, 0, 0, 0, 0, 0, DIR_UP, 0));
		add_row(make_item(CMD_SELECT, 0, 0, -32768, 32767, 0, 0, 0, DIR_UP, 0));
		add_row(make_item(CMD_SELECT, 0, 0, -32768, 32767, 0, 0, 0, DIR_UP, 1));
		add_row(make_item(CMD_BEGIN, 0, 0, 0, 0, 0, 0, 0, DIR_UP, 0));
		add_row(make_item(CMD_REGISTER, 4, 4, 50, 50, 8, 8, 1, DIR_UP, 0));
		add_row(make_item(CMD_REGISTER, 4, 5, -300, 20, 8, 8, 1, DIR_UP, 0));
		add_row(make_item(CMD_END, 0, 0, 0, 0, 0, 0, 0, DIR_UP, 1));

		// Random part: frames with random content, commands on the built table, noise.
		while (stim_rows.size() < 25 + RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) == 0) begin
				add_row(noise_item());
				continue;
			end
			add_row(make_item(CMD_BEGIN, 0, 0, 0, 0, 0, 0, 0, DIR_UP, 0));
			big = $urandom_range(0, 11) == 0;
			n = big ? $urandom_range(62, 68) : $urandom_range(0, 8);
			for (int k = 0; k < n; k++) begin
				add_row(random_register(big, k));
			end
			if ($urandom_range(0, 7) == 0) add_row(noise_item());
			it = noise_item();
			it.command = CMD_END;
			add_row(it);
			repeat ($urandom_range(1, 8)) begin
				it = noise_item();
				case ($urandom_range(0, 5))
					0, 1, 2: it.command = CMD_MOVE;
					3: begin
						it.command = CMD_SET;
						if ($urandom_range(0, 2) != 0) begin
							it.owner = $urandom_range(1, 3);
							it.id = $urandom_range(0, 3);
						end
					end
					4: it.command = CMD_SELECT;
					default: it.command = $urandom_range(0, 5) == 0 ? CMD_CLEAR : CMD_MOVE;
				endcase
				add_row(it);
			end
		end
	endfunction

	function automatic int idle_pct(bit sink_side);
		if (loaded < stim_rows.size() / 3) return sink_side ? 48 : 36;
		if (loaded < 2 * stim_rows.size() / 3) return sink_side ? 36 : 48;
		return 0;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		shadow_count = 0;
		drop_focus();
		saved_cx2 = 0;
		saved_cy2 = 0;
		saved_valid = 1'b0;
		shadow_collecting = 1'b0;
		build_stimulus();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		wait (taken == stim_rows.size() && pending_focus.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_focus.size() == 0) begin
			$display("tb_directional_focus_selector_core: clean");
		end else begin
			$display("tb_directional_focus_selector_core: errors");
		end
		$finish;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_directional_focus_selector_core: errors");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			request.valid <= 1'b0;
			request.command <= '0;
			request.owner_key <= '0;
			request.entry_id <= '0;
			request.pos_x <= '0;
			request.pos_y <= '0;
			request.rect_width <= '0;
			request.rect_height <= '0;
			request.entry_enabled <= 1'b0;
			request.move_direction <= '0;
			request.point_valid <= 1'b0;
		end else if (!request.valid || request.ready) begin
			if (loaded < stim_rows.size() && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
				request.command <= stim_rows[loaded].cmd_item.command;
				request.owner_key <= stim_rows[loaded].cmd_item.owner;
				request.entry_id <= stim_rows[loaded].cmd_item.id;
				request.pos_x <= stim_rows[loaded].cmd_item.x;
				request.pos_y <= stim_rows[loaded].cmd_item.y;
				request.rect_width <= stim_rows[loaded].cmd_item.w;
				request.rect_height <= stim_rows[loaded].cmd_item.h;
				request.entry_enabled <= stim_rows[loaded].cmd_item.enabled;
				request.move_direction <= stim_rows[loaded].cmd_item.dir;
				request.point_valid <= stim_rows[loaded].cmd_item.pv;
				drive_fixed <= stim_rows[loaded].fixed;
				drive_res <= stim_rows[loaded].fixed_res;
				loaded <= loaded + 1;
				request.valid <= 1'b1;
			end else begin
				request.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			response.ready <= 1'b0;
		end else begin
			response.ready <= $urandom_range(0, 99) >= idle_pct(1'b1);
		end
	end

	// The predictor always runs so its state stays in step; rows with a fixed
	// expectation replace only the value that is checked.
	always @(posedge clk) begin
		item_t it;
		focus_res_t r;
		if (arst_n && request.valid && request.ready) begin
			it = '{command: request.command, owner: request.owner_key, id: request.entry_id,
				x: request.pos_x, y: request.pos_y, w: request.rect_width,
				h: request.rect_height, enabled: request.entry_enabled,
				dir: request.move_direction, pv: request.point_valid};
			r = focus_after(it);
			pending_focus.insert(pending_focus.size(), drive_fixed ? drive_res : r);
			taken <= taken + 1;
		end
	end

	always @(posedge clk) begin
		focus_res_t got;
		focus_res_t want;
		if (arst_n && response.valid && response.ready) begin
			got = '{accepted: response.accepted, focus_valid: response.focus_valid,
				owner: response.focus_owner, id: response.focus_id, x: response.focus_x,
				y: response.focus_y, w: response.focus_width, h: response.focus_height,
				table_full: response.table_full};
			if (pending_focus.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10) $display("unexpected result item %p", got);
			end else begin
				want = pending_focus.pop_front();
				if (got !== want) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10) $display("mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

endmodule

// ===== filelist.f =====
src/dfs_pkg.sv
src/dfs_if.sv
src/dfs_ctrl.sv
src/dfs_datapath.sv
src/directional_focus_selector_core.sv
tb/tb_directional_focus_selector_core.sv
